>>> design/tprs_pkg.sv
// Shared types, constants and control structs of the timer prescaler/reload solver.
// No dependencies; all other design files import this package.
package tprs_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DIV_W       = 33;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  localparam logic [COUNT_WIDTH-1:0] MAX_COUNT = '1;
  localparam longint unsigned        MAX_L     = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [DIV_W-1:0]       SPLIT_LIMIT = DIV_W'(MAX_L * MAX_L);
  localparam logic [DIV_W-1:0]       DIV_LIMIT   = DIV_W'(32'h7FFF_FFFF);
  localparam logic [31:0]            CLOCK_RESET = 32'd170_000_000;

  localparam logic [1:0] ST_EXACT    = 2'd0;
  localparam logic [1:0] ST_INEXACT  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  typedef struct packed {
    logic [31:0] req_value;
    logic        freq_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] prescale;
    logic [15:0] reload;
    logic [31:0] real_freq;
  } out_item_t;

  typedef enum logic [1:0] {
    DSEL_FREQ,
    DSEL_SPLIT,
    DSEL_RATE
  } dsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENTRY,
    S_FDIV,
    S_CHECK,
    S_SDIV,
    S_SEARCH,
    S_MULT,
    S_RSTART,
    S_RDIV,
    S_ERR
  } ctl_state_t;

  typedef struct packed {
    logic  load;
    logic  div_start;
    dsel_t div_sel;
    logic  freq_div;
    logic  direct;
    logic  srch_init;
    logic  srch_step;
    logic  split_fin;
    logic  mult;
    logic  emit;
    logic  emit_err;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic zero_req;
    logic fmode;
    logic div_bad;
    logic div_small;
    logic srch_done;
  } dp_stat_t;

endpackage

>>> design/tprs_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, DIV_W-bit operands.
// Depends on tprs_pkg.
module tprs_div
  import tprs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_W:0]       shifted;
  logic [DIV_W+1:0]     diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(DIV_W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!diff[DIV_W+1]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> design/tprs_dpath.sv
// Datapath: clock register, divisor forming, incremental factor search, product
// and result register. Depends on tprs_pkg and tprs_div.
module tprs_dpath
  import tprs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata,
  input  in_item_t  in_item,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output logic      out_strobe,
  output out_item_t out_result
);

  localparam int W = COUNT_WIDTH;

  logic [31:0]           clk_hz_r;
  logic [31:0]           req_r;
  logic                  fmode_r;
  logic [DIV_W-1:0]      d_r;
  logic [W-1:0]          c_r, q_r, best_r, bestq_r;
  logic signed [W+1:0]   r_r;
  logic [W:0]            bestrem_r;
  logic                  srch_done_r, found_r;
  logic [W-1:0]          psc_r, arr_r;
  logic [1:0]            status_r;
  logic [DIV_W-1:0]      prod_r;
  logic                  out_strobe_r;
  out_item_t             out_r;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dvd, div_dvs, div_quo, div_rem;
  logic                  div_done;
  logic [DIV_W:0]        round_sum;
  logic [W-1:0]          rem_w, c0, fa, fb;
  logic [2*W+1:0]        prod_full;

  tprs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    c0 = W'(d_r >> W) + 1'b1;
    div_start = cmd.div_start;
    case (cmd.div_sel)
      DSEL_FREQ: begin
        div_dvd = {clk_hz_r, 1'b0};
        div_dvs = DIV_W'(req_r);
      end
      DSEL_SPLIT: begin
        div_dvd = d_r;
        div_dvs = DIV_W'(c0);
      end
      DSEL_RATE: begin
        div_dvd = DIV_W'(clk_hz_r);
        div_dvs = prod_r;
      end
      default: begin
        div_dvd = '0;
        div_dvs = DIV_W'(1);
      end
    endcase
    round_sum = {1'b0, div_quo} + 1'b1;
    rem_w     = r_r[W-1:0];
    fa        = best_r;
    fb        = bestq_r;
    prod_full = ({1'b0, psc_r} + 1'b1) * ({1'b0, arr_r} + 1'b1);
  end

  assign stat.div_done  = div_done;
  assign stat.zero_req  = fmode_r && (req_r == '0);
  assign stat.fmode     = fmode_r;
  assign stat.div_bad   = (d_r == '0) || (d_r > DIV_LIMIT) || (d_r > SPLIT_LIMIT);
  assign stat.div_small = (d_r <= DIV_W'(MAX_COUNT));
  assign stat.srch_done = srch_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r     <= CLOCK_RESET;
      out_strobe_r <= 1'b0;
      srch_done_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        clk_hz_r <= cfg_wdata;
      end
      out_strobe_r <= cmd.emit || cmd.emit_err;
      if (cmd.srch_init) begin
        srch_done_r <= 1'b0;
      end else if (cmd.srch_step && !srch_done_r && !r_r[W+1] &&
                   ((rem_w == '0) || (c_r == MAX_COUNT))) begin
        srch_done_r <= 1'b1;
      end
    end

    if (cmd.load) begin
      req_r   <= in_item.req_value;
      fmode_r <= in_item.freq_mode;
      d_r     <= DIV_W'(in_item.req_value);
    end
    if (cmd.freq_div) begin
      d_r <= round_sum[DIV_W:1];
    end

    if (cmd.srch_init) begin
      c_r       <= c0;
      q_r       <= div_quo[W-1:0];
      r_r       <= $signed({2'b00, div_rem[W-1:0]});
      bestrem_r <= '1;
      best_r    <= c0;
      bestq_r   <= div_quo[W-1:0];
      found_r   <= 1'b0;
    end else if (cmd.srch_step && !srch_done_r) begin
      if (r_r[W+1]) begin
        // fold the negative remainder back, one quotient step per cycle
        r_r <= r_r + $signed({2'b00, c_r});
        q_r <= q_r - 1'b1;
      end else begin
        if ({1'b0, rem_w} < bestrem_r) begin
          bestrem_r <= {1'b0, rem_w};
          best_r    <= c_r;
          bestq_r   <= q_r;
        end
        if (rem_w == '0) begin
          found_r <= 1'b1;
        end else if (c_r != MAX_COUNT) begin
          c_r <= c_r + 1'b1;
          r_r <= r_r - $signed({2'b00, q_r});
        end
      end
    end

    if (cmd.direct) begin
      psc_r    <= '0;
      arr_r    <= d_r[W-1:0] - 1'b1;
      status_r <= ST_EXACT;
    end
    if (cmd.split_fin) begin
      if (fa > fb) begin
        psc_r <= fb - 1'b1;
        arr_r <= fa - 1'b1;
      end else begin
        psc_r <= fa - 1'b1;
        arr_r <= fb - 1'b1;
      end
      status_r <= found_r ? ST_EXACT : ST_INEXACT;
    end
    if (cmd.mult) begin
      prod_r <= DIV_W'(prod_full);
    end

    if (cmd.emit) begin
      out_r.status    <= status_r;
      out_r.prescale  <= 16'(psc_r);
      out_r.reload    <= 16'(arr_r);
      out_r.real_freq <= div_quo[31:0];
    end else if (cmd.emit_err) begin
      out_r.status    <= ST_MISMATCH;
      out_r.prescale  <= '0;
      out_r.reload    <= '0;
      out_r.real_freq <= '0;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

endmodule

>>> design/tprs_ctrl.sv
// Controller state machine: sequences the divides, the factor search and the
// result transfer. Depends on tprs_pkg.
module tprs_ctrl
  import tprs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DSEL_FREQ;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (stat.zero_req) begin
          state_nxt = S_ERR;
        end else if (stat.fmode) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_FREQ;
          state_nxt     = S_FDIV;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_FDIV: begin
        if (stat.div_done) begin
          cmd.freq_div = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.div_bad) begin
          state_nxt = S_ERR;
        end else if (stat.div_small) begin
          cmd.direct = 1'b1;
          state_nxt  = S_MULT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_SPLIT;
          state_nxt     = S_SDIV;
        end
      end
      S_SDIV: begin
        if (stat.div_done) begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.srch_done) begin
          cmd.split_fin = 1'b1;
          state_nxt     = S_MULT;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_RSTART;
      end
      S_RSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_RATE;
        state_nxt     = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_sel = DSEL_RATE;
        if (stat.div_done) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.emit_err = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> design/timer_prescaler_reload_solver_unit.sv
// A small raw divisor goes from the accepting edge through the checks, the direct split, the
// product and the rate divide to the result strobe; a frequency request adds the frequency
// divide; a split adds the split divide and a search step per candidate factor and step-down.
// One item at a time: busy stays high from the accepting edge until the cycle of the result
// strobe. Synchronous active-low reset returns to idle and sets clock_hz to 170 MHz.
// Top level: ties tprs_ctrl and tprs_dpath together. Depends on tprs_pkg.
module timer_prescaler_reload_solver_unit
  import tprs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_result,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  tprs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  tprs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

>>> design/tprs_chk.sv
// Port-level checker for the solver top level, attached by bind.
// Depends on tprs_pkg.
module tprs_chk
  import tprs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_result
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_mismatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.status == ST_MISMATCH |->
      out_result.prescale == '0 && out_result.reload == '0 && out_result.real_freq == '0)
    else $error("mismatch result with nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_result.status == ST_EXACT || out_result.status == ST_INEXACT ||
                   out_result.status == ST_MISMATCH)
    else $error("undefined status code");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_result.prescale <= out_result.reload)
    else $error("prescale exceeds reload");

endmodule

bind timer_prescaler_reload_solver_unit tprs_chk u_tprs_chk (.*);

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench for timer_prescaler_reload_solver_unit: directed and random rate requests
// checked against an in-bench prescaler/reload split model. Depends on tprs_pkg.
module tb;
  import tprs_pkg::*;

  localparam logic FREQ_REQ = 1'b1;
  localparam logic DIV_REQ  = 1'b0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    req_item = '0;
  logic        out_strobe;
  out_item_t   res_item;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] clock_cfg = CLOCK_RESET;
  int          idle_pct = 0;
  int          mismatches = 0;
  out_item_t   timer_settings_q[$];
  out_item_t   want;

  timer_prescaler_reload_solver_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (req_item),
    .out_strobe (out_strobe),
    .out_result (res_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t solve_timer_split(in_item_t rq, logic [31:0] hz);
    longint unsigned hz64, req64, dv, d, cand, best, best_rem, rem, fa, fb, psc, arr, prod;
    logic            found;
    out_item_t       r;
    r = '0;
    hz64 = hz;
    req64 = rq.req_value;
    if (rq.freq_mode == FREQ_REQ) begin
      if (req64 == 0) begin
        r.status = ST_MISMATCH;
        return r;
      end
      // round to nearest divisor
      dv = ((2 * hz64) / req64 + 1) / 2;
    end else begin
      dv = req64;
    end
    if (dv == 0 || dv > DIV_LIMIT || dv > SPLIT_LIMIT) begin
      r.status = ST_MISMATCH;
      return r;
    end
    if (dv <= MAX_L) begin
      psc = 0;
      arr = dv - 1;
      r.status = ST_EXACT;
    end else begin
      d = dv;
      cand = (d >> COUNT_WIDTH) + 1;
      best = cand;
      best_rem = 64'hFFFF_FFFF;
      found = 1'b0;
      while (cand <= MAX_L && !found) begin
        rem = d % cand;
        if (rem < best_rem) begin
          best_rem = rem;
          best = cand;
        end
        if (rem == 0) found = 1'b1;
        else cand++;
      end
      fa = best;
      fb = d / best;
      // larger factor goes to reload
      if (fa > fb) begin
        psc = fb - 1;
        arr = fa - 1;
      end else begin
        psc = fa - 1;
        arr = fb - 1;
      end
      r.status = found ? ST_EXACT : ST_INEXACT;
    end
    prod = (psc + 1) * (arr + 1);
    r.prescale = psc[15:0];
    r.reload = arr[15:0];
    r.real_freq = 32'(hz64 / prod);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (timer_settings_q.size() == 0) begin
        $error("result transfer with no request pending");
        mismatches++;
      end else begin
        want = timer_settings_q.pop_front();
        if (res_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_item.status);
          mismatches++;
        end
        if (res_item.prescale !== want.prescale) begin
          $error("prescale: expected %0d, got %0d", want.prescale, res_item.prescale);
          mismatches++;
        end
        if (res_item.reload !== want.reload) begin
          $error("reload: expected %0d, got %0d", want.reload, res_item.reload);
          mismatches++;
        end
        if (res_item.real_freq !== want.real_freq) begin
          $error("real_freq: expected %0d, got %0d", want.real_freq, res_item.real_freq);
          mismatches++;
        end
      end
    end
  end

  task automatic send_request(input logic [31:0] value, input logic mode);
    in_item_t it;
    it.req_value = value;
    it.freq_mode = mode;
    @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      // hold off past the end of the current job
      while (busy) @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    req_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    timer_settings_q.push_back(solve_timer_split(it, clock_cfg));
    start <= 1'b0;
  endtask

  task automatic wait_all_settled();
    while (timer_settings_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_clock(input logic [31:0] hz);
    wait_all_settled();
    @(posedge clk);
    cfg_wdata <= hz;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    clock_cfg = hz;
  endtask

  task automatic test_raw_divisors();
    send_request(32'd0, DIV_REQ);
    send_request(32'd1, DIV_REQ);
    send_request(32'd2, DIV_REQ);
    send_request(32'd65535, DIV_REQ);
    send_request(32'd65536, DIV_REQ);
    send_request(32'd66049, DIV_REQ);        // 257 squared: equal factors
    send_request(32'd196563, DIV_REQ);       // 3 * 65521: the first candidate divides exactly
    send_request(32'd65537, DIV_REQ);        // prime: full search, inexact
    send_request(32'h7FFF_FFFF, DIV_REQ);
    send_request(32'h8000_0000, DIV_REQ);
    send_request(32'hFFFF_FFFF, DIV_REQ);
  endtask

  task automatic test_freq_requests();
    send_request(32'd0, FREQ_REQ);
    send_request(32'd1, FREQ_REQ);
    send_request(32'd7000, FREQ_REQ);        // rounds the divisor up
    send_request(32'd170_000_000, FREQ_REQ);
    send_request(32'd340_000_000, FREQ_REQ);
    send_request(32'd680_000_000, FREQ_REQ);
    send_request(32'hFFFF_FFFF, FREQ_REQ);
  endtask

  task automatic test_clock_extremes();
    set_clock(32'hFFFF_FFFF);
    send_request(32'd1, FREQ_REQ);
    send_request(32'd3, FREQ_REQ);
    send_request(32'h8000_0000, FREQ_REQ);
    send_request(32'd1000, DIV_REQ);
    set_clock(32'd1);
    send_request(32'd1, FREQ_REQ);
    send_request(32'd3, FREQ_REQ);
    send_request(32'd65535, DIV_REQ);
    set_clock(32'd0);
    send_request(32'd5, FREQ_REQ);
    send_request(32'd100, DIV_REQ);
  endtask

  task automatic test_random_mix(input int pct, input int n_items, input logic [31:0] hz);
    int          pick;
    logic [31:0] f1, f2, hi, lo;
    idle_pct = pct;
    set_clock(hz);
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_all_settled();
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_request($urandom_range(65535, 0), DIV_REQ);
      end else if (pick < 75) begin
        // product with one factor near the top: short search
        f2 = $urandom_range(65535, 60000);
        hi = 32'h7FFF_FFFF / f2;
        if (hi > 32767) hi = 32767;
        f1 = $urandom_range(hi, 2);
        send_request(f1 * f2, DIV_REQ);
      end else if (pick < 90) begin
        lo = (hz >> 15) + 1;
        send_request($urandom_range(32'hFFFF_FFFF, lo), FREQ_REQ);
      end else if (pick < 96) begin
        send_request($urandom | 32'h8000_0000, DIV_REQ);
      end else begin
        send_request($urandom_range(32'h7FFF_FFFF, 32'h7000_0000), DIV_REQ);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 36;
    test_raw_divisors();
    test_freq_requests();
    test_clock_extremes();
    test_random_mix(36, 24, $urandom);
    test_random_mix(67, 24, CLOCK_RESET);
    test_random_mix(0, 24, $urandom_range(32'hFFFF_FFFF, 32'h1000_0000));
    wait_all_settled();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && timer_settings_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
